// ----- hdl/tccb_pkg.sv -----
// ----------------------------------------------------------------------------
// tccb_pkg
// Types, constants and helper functions shared by the text console cell buffer.
// ----------------------------------------------------------------------------
package tccb_pkg;

  localparam int unsigned LINE_COUNT   = 64;
  localparam int unsigned COLUMN_COUNT = 128;
  localparam int unsigned CELLS        = LINE_COUNT * COLUMN_COUNT;

  localparam int unsigned LINE_W  = $clog2(LINE_COUNT);
  localparam int unsigned COL_W   = $clog2(COLUMN_COUNT);
  localparam int unsigned CCOL_W  = $clog2(COLUMN_COUNT + 1);
  localparam int unsigned ADDR_W  = $clog2(CELLS);
  localparam int unsigned RV_W    = 7;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned BOT_W   = (LINE_W + 1 > RV_W) ? LINE_W + 1 : RV_W;

  localparam logic [RV_W-1:0]    RESET_ROWS_VISIBLE = RV_W'(25);
  localparam logic [COLOR_W-1:0] RESET_DEFAULT_FG   = 24'hCCDDFF;
  localparam logic [COLOR_W-1:0] RESET_DEFAULT_BG   = 24'h050508;

  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_VISIBLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BG   = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_PUT       = 3'd0,
    OP_VIEW_UP   = 3'd1,
    OP_VIEW_DOWN = 3'd2,
    OP_CLEAR     = 3'd3,
    OP_READ      = 3'd4
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_FILL
  } state_e;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } cell_t;

  // Ring addition of two line numbers modulo LINE_COUNT.
  function automatic logic [LINE_W-1:0] line_add(input logic [LINE_W-1:0] a,
                                                 input logic [LINE_W-1:0] b);
    logic [LINE_W:0] sum;
    begin
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (LINE_W+1)'(LINE_COUNT)) begin
        sum = sum - (LINE_W+1)'(LINE_COUNT);
      end
      line_add = sum[LINE_W-1:0];
    end
  endfunction

  // Lowest view line that still shows the given cursor line.
  function automatic logic [LINE_W-1:0] bottom_line(input logic [LINE_W-1:0] row,
                                                    input logic [RV_W-1:0]   rv);
    logic [BOT_W-1:0] rows;
    logic [BOT_W-1:0] next;
    logic [BOT_W-1:0] diff;
    begin
      rows = (rv == '0) ? BOT_W'(1) : BOT_W'(rv);
      next = BOT_W'(row) + BOT_W'(1);
      diff = (next >= rows) ? next - rows : '0;
      bottom_line = diff[LINE_W-1:0];
    end
  endfunction

  // Raises the view so that the cursor line stays visible.
  function automatic logic [LINE_W-1:0] follow_view(input logic [LINE_W-1:0] view,
                                                    input logic [LINE_W-1:0] row,
                                                    input logic [RV_W-1:0]   rv);
    logic [LINE_W-1:0] bot;
    begin
      bot = bottom_line(row, rv);
      follow_view = (view < bot) ? bot : view;
    end
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [LINE_W-1:0] line,
                                                  input logic [COL_W-1:0]  col);
    cell_addr = ADDR_W'(line) * ADDR_W'(COLUMN_COUNT) + ADDR_W'(col);
  endfunction

endpackage

// ----- hdl/text_console_cell_buffer.sv -----
// ----------------------------------------------------------------------------
// text_console_cell_buffer
// Character-cell console store with a ring of lines and scrollback view.
// ----------------------------------------------------------------------------
// Usage: a command word is taken at a rising edge where start_i is high and
// busy_o is low. The opcode selects put character, view up, view down, clear
// or read cell. Every command produces exactly one result word, shown on the
// result ports for one cycle with done_o high; the receiver has no way to hold
// it off. The result reports the cursor and the view after the command, and
// for a read also the cell contents.
// Latency: the result appears in the cycle after the command is taken. Most
// commands leave busy_o low, so a new command may follow in every cycle.
// The first character written into a blank line fills that line in the cell
// memory, one cell per cycle over its single write port, which keeps busy_o
// high until the last cell of the line is written, and only then is the result shown.
// Configuration writes through cfg_we_i, cfg_addr_i and cfg_wdata_i take
// effect at once and are meant for times when no command is in flight.
// Reset marks every line blank and clears cursor, view and ring base; the
// cell memory itself is not cleared, since blank lines are never read from it.
// ----------------------------------------------------------------------------
module text_console_cell_buffer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [tccb_pkg::OP_W-1:0]           opcode_i,
  input  logic [tccb_pkg::CHAR_W-1:0]         char_code_i,
  input  logic [tccb_pkg::COLOR_W-1:0]        fg_color_i,
  input  logic [tccb_pkg::COLOR_W-1:0]        bg_color_i,
  input  logic [tccb_pkg::LINE_W-1:0]         read_row_i,
  input  logic [tccb_pkg::COL_W-1:0]          read_col_i,
  input  logic                                cfg_we_i,
  input  logic [tccb_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [tccb_pkg::COLOR_W-1:0]        cfg_wdata_i,
  output logic                                done_o,
  output logic [tccb_pkg::CHAR_W-1:0]         cell_char_o,
  output logic [tccb_pkg::COLOR_W-1:0]        cell_fg_o,
  output logic [tccb_pkg::COLOR_W-1:0]        cell_bg_o,
  output logic [tccb_pkg::LINE_W-1:0]         cursor_row_o,
  output logic [tccb_pkg::CCOL_W-1:0]         cursor_col_o,
  output logic [tccb_pkg::LINE_W-1:0]         view_top_o
);

  // Configuration registers.
  logic [tccb_pkg::RV_W-1:0]    rows_visible_q;
  logic [tccb_pkg::COLOR_W-1:0] default_fg_q;
  logic [tccb_pkg::COLOR_W-1:0] default_bg_q;

  // Console state.
  tccb_pkg::state_e                state_q, state_d;
  logic [tccb_pkg::LINE_W-1:0]     base_q, base_d;
  logic [tccb_pkg::LINE_W-1:0]     row_q, row_d;
  logic [tccb_pkg::CCOL_W-1:0]     col_q, col_d;
  logic [tccb_pkg::LINE_W-1:0]     view_q, view_d;
  logic [tccb_pkg::LINE_COUNT-1:0] blank_q, blank_d;

  // Result side.
  logic done_q, done_d;
  logic is_read_q, is_read_d;
  logic rd_blank_q, rd_blank_d;

  // Line fill sequencer.
  logic [tccb_pkg::LINE_W-1:0] fill_line_q, fill_line_d;
  logic [tccb_pkg::COL_W-1:0]  fill_cnt_q, fill_cnt_d;
  logic [tccb_pkg::COL_W-1:0]  fill_col_q, fill_col_d;
  tccb_pkg::cell_t             fill_cell_q, fill_cell_d;

  // Cell memory port.
  tccb_pkg::cell_t               cell_mem [tccb_pkg::CELLS];
  tccb_pkg::cell_t               mem_rdata_q;
  tccb_pkg::cell_t               mem_wdata;
  tccb_pkg::cell_t               blank_cell;
  logic [tccb_pkg::ADDR_W-1:0]   mem_addr;
  logic                          mem_we;
  logic                          mem_re;

  // Precomputed effects of a newline and of a stored character.
  logic                        accept;
  logic                        nl_last;
  logic [tccb_pkg::LINE_W-1:0] nl_base;
  logic [tccb_pkg::LINE_W-1:0] nl_row;
  logic [tccb_pkg::LINE_W-1:0] nl_view;
  logic [tccb_pkg::LINE_W-1:0] nl_phys;
  logic [tccb_pkg::LINE_W-1:0] cur_phys;
  logic [tccb_pkg::LINE_W-1:0] rd_phys;
  logic                        wrap;
  logic [tccb_pkg::LINE_W-1:0] pc_row;
  logic [tccb_pkg::LINE_W-1:0] pc_base;
  logic [tccb_pkg::LINE_W-1:0] pc_phys;
  logic [tccb_pkg::COL_W-1:0]  pc_col;
  logic                        pc_blank;
  logic [tccb_pkg::LINE_W-1:0] pc_view;
  logic [tccb_pkg::COL_W-1:0]  bs_col;

  assign accept     = start_i && (state_q == tccb_pkg::ST_IDLE);
  assign blank_cell = '{ch: tccb_pkg::CH_SPACE, fg: default_fg_q, bg: default_bg_q};

  // On the last line a newline scrolls by advancing the ring base.
  assign nl_last  = (row_q == tccb_pkg::LINE_W'(tccb_pkg::LINE_COUNT - 1));
  assign nl_base  = nl_last ? tccb_pkg::line_add(base_q, tccb_pkg::LINE_W'(1)) : base_q;
  assign nl_row   = nl_last ? row_q : row_q + tccb_pkg::LINE_W'(1);
  assign nl_view  = tccb_pkg::follow_view(
                      (nl_last && (view_q != '0)) ? view_q - tccb_pkg::LINE_W'(1) : view_q,
                      nl_row, rows_visible_q);
  assign nl_phys  = tccb_pkg::line_add(nl_base, nl_row);
  assign cur_phys = tccb_pkg::line_add(base_q, row_q);
  assign rd_phys  = tccb_pkg::line_add(base_q, read_row_i);

  // A stored character first wraps when a wrap is pending; the line it
  // lands on is then freshly blanked, so it always needs a fill.
  assign wrap     = (col_q == tccb_pkg::CCOL_W'(tccb_pkg::COLUMN_COUNT));
  assign pc_row   = wrap ? nl_row : row_q;
  assign pc_base  = wrap ? nl_base : base_q;
  assign pc_phys  = wrap ? nl_phys : cur_phys;
  assign pc_col   = wrap ? '0 : col_q[tccb_pkg::COL_W-1:0];
  assign pc_blank = wrap || blank_q[cur_phys];
  assign pc_view  = tccb_pkg::follow_view(wrap ? nl_view : view_q, pc_row, rows_visible_q);
  assign bs_col   = tccb_pkg::COL_W'(col_q - tccb_pkg::CCOL_W'(1));

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    row_d       = row_q;
    col_d       = col_q;
    view_d      = view_q;
    blank_d     = blank_q;
    done_d      = 1'b0;
    is_read_d   = is_read_q;
    rd_blank_d  = rd_blank_q;
    fill_line_d = fill_line_q;
    fill_cnt_d  = fill_cnt_q;
    fill_col_d  = fill_col_q;
    fill_cell_d = fill_cell_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = '0;
    mem_wdata   = blank_cell;

    unique case (state_q)
      tccb_pkg::ST_IDLE: begin
        if (accept) begin
          done_d    = 1'b1;
          is_read_d = 1'b0;
          unique case (tccb_pkg::op_e'(opcode_i))
            tccb_pkg::OP_PUT: begin
              priority if (char_code_i == tccb_pkg::CH_NEWLINE) begin
                base_d           = nl_base;
                row_d            = nl_row;
                col_d            = '0;
                view_d           = nl_view;
                blank_d[nl_phys] = 1'b1;
              end else if (char_code_i == tccb_pkg::CH_RETURN) begin
                col_d = '0;
              end else if (char_code_i == tccb_pkg::CH_BACKSPACE) begin
                if (col_q != '0) begin
                  col_d = col_q - tccb_pkg::CCOL_W'(1);
                  if (!blank_q[cur_phys]) begin
                    mem_we   = 1'b1;
                    mem_addr = tccb_pkg::cell_addr(cur_phys, bs_col);
                  end
                end
              end else begin
                base_d = pc_base;
                row_d  = pc_row;
                col_d  = tccb_pkg::CCOL_W'(pc_col) + tccb_pkg::CCOL_W'(1);
                view_d = pc_view;
                if (pc_blank) begin
                  // The whole line gets blanked in memory, with this
                  // character dropped in at its column on the way.
                  blank_d[pc_phys] = 1'b0;
                  done_d           = 1'b0;
                  state_d          = tccb_pkg::ST_FILL;
                  fill_line_d      = pc_phys;
                  fill_cnt_d       = '0;
                  fill_col_d       = pc_col;
                  fill_cell_d      = '{ch: char_code_i, fg: fg_color_i, bg: bg_color_i};
                end else begin
                  mem_we    = 1'b1;
                  mem_addr  = tccb_pkg::cell_addr(pc_phys, pc_col);
                  mem_wdata = '{ch: char_code_i, fg: fg_color_i, bg: bg_color_i};
                end
              end
            end
            tccb_pkg::OP_VIEW_UP: begin
              if (view_q != '0) begin
                view_d = view_q - tccb_pkg::LINE_W'(1);
              end
            end
            tccb_pkg::OP_VIEW_DOWN: begin
              if (view_q < tccb_pkg::bottom_line(row_q, rows_visible_q)) begin
                view_d = view_q + tccb_pkg::LINE_W'(1);
              end
            end
            tccb_pkg::OP_CLEAR: begin
              base_d  = '0;
              row_d   = '0;
              col_d   = '0;
              view_d  = '0;
              blank_d = '1;
            end
            tccb_pkg::OP_READ: begin
              is_read_d  = 1'b1;
              rd_blank_d = blank_q[rd_phys];
              mem_re     = 1'b1;
              mem_addr   = tccb_pkg::cell_addr(rd_phys, read_col_i);
            end
            default: begin
            end
          endcase
        end
      end
      tccb_pkg::ST_FILL: begin
        mem_we     = 1'b1;
        mem_addr   = tccb_pkg::cell_addr(fill_line_q, fill_cnt_q);
        mem_wdata  = (fill_cnt_q == fill_col_q) ? fill_cell_q : blank_cell;
        fill_cnt_d = fill_cnt_q + tccb_pkg::COL_W'(1);
        if (fill_cnt_q == tccb_pkg::COL_W'(tccb_pkg::COLUMN_COUNT - 1)) begin
          state_d = tccb_pkg::ST_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = tccb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= tccb_pkg::ST_IDLE;
      base_q         <= '0;
      row_q          <= '0;
      col_q          <= '0;
      view_q         <= '0;
      blank_q        <= '1;
      done_q         <= 1'b0;
      is_read_q      <= 1'b0;
      rd_blank_q     <= 1'b0;
      fill_cnt_q     <= '0;
      rows_visible_q <= tccb_pkg::RESET_ROWS_VISIBLE;
      default_fg_q   <= tccb_pkg::RESET_DEFAULT_FG;
      default_bg_q   <= tccb_pkg::RESET_DEFAULT_BG;
    end else begin
      state_q    <= state_d;
      base_q     <= base_d;
      row_q      <= row_d;
      col_q      <= col_d;
      view_q     <= view_d;
      blank_q    <= blank_d;
      done_q     <= done_d;
      is_read_q  <= is_read_d;
      rd_blank_q <= rd_blank_d;
      fill_cnt_q <= fill_cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          tccb_pkg::CFG_ROWS_VISIBLE: rows_visible_q <= cfg_wdata_i[tccb_pkg::RV_W-1:0];
          tccb_pkg::CFG_DEFAULT_FG:   default_fg_q   <= cfg_wdata_i;
          tccb_pkg::CFG_DEFAULT_BG:   default_bg_q   <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Fill sequencer payload needs no reset.
  always_ff @(posedge clk_i) begin
    fill_line_q <= fill_line_d;
    fill_col_q  <= fill_col_d;
    fill_cell_q <= fill_cell_d;
  end

  // Single-port cell memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= cell_mem[mem_addr];
    end
  end

  // A blank line reads as a space in the current default colors; every
  // command other than a read reports a zero cell.
  always_comb begin
    if (!is_read_q) begin
      cell_char_o = '0;
      cell_fg_o   = '0;
      cell_bg_o   = '0;
    end else if (rd_blank_q) begin
      cell_char_o = tccb_pkg::CH_SPACE;
      cell_fg_o   = default_fg_q;
      cell_bg_o   = default_bg_q;
    end else begin
      cell_char_o = mem_rdata_q.ch;
      cell_fg_o   = mem_rdata_q.fg;
      cell_bg_o   = mem_rdata_q.bg;
    end
  end

  assign busy_o       = (state_q == tccb_pkg::ST_FILL);
  assign done_o       = done_q;
  assign cursor_row_o = row_q;
  assign cursor_col_o = col_q;
  assign view_top_o   = view_q;

endmodule

// ----- hdl/tccb_checker.sv -----
// ----------------------------------------------------------------------------
// tccb_checker
// Port-level checks for the text console cell buffer, bound to the top level.
// ----------------------------------------------------------------------------
module tccb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic [tccb_pkg::OP_W-1:0]       opcode_i,
  input logic                            done_o,
  input logic [tccb_pkg::CHAR_W-1:0]     cell_char_o,
  input logic [tccb_pkg::CCOL_W-1:0]     cursor_col_o,
  input logic [tccb_pkg::LINE_W-1:0]     cursor_row_o
);

  // No word is delivered while a line fill is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !done_o)
    else $error("result strobe during line fill");

  // A taken command is answered in the next cycle or starts a fill.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (done_o || busy_o))
    else $error("command neither answered nor filling");

  // The end of a fill always delivers its word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("fill ended without a result");

  // A nonzero cell character can only come from a read command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (cell_char_o != '0)) |->
      $past(start_i && !busy_o && (opcode_i == tccb_pkg::OP_READ)))
    else $error("cell data reported for a non-read command");

  // The cursor does not move while a fill runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && $past(busy_o)) |-> ($stable(cursor_col_o) && $stable(cursor_row_o)))
    else $error("cursor moved during line fill");

endmodule

bind text_console_cell_buffer tccb_checker u_tccb_checker (.*);
